### src/cdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types, request codes and controller/datapath handshake structs for
// the character display difference-refresh block.
// ----------------------------------------------------------------------------
package cdr_pkg;

	localparam int DEF_COLUMNS = 16;
	localparam int DEF_ROWS    = 2;

	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// request codes
	localparam logic [2:0] REQ_PUT_POS   = 3'd0;
	localparam logic [2:0] REQ_PUT_CUR   = 3'd1;
	localparam logic [2:0] REQ_SET_CUR   = 3'd2;
	localparam logic [2:0] REQ_CLR_SPAN  = 3'd3;
	localparam logic [2:0] REQ_CLR_ALL   = 3'd4;
	localparam logic [2:0] REQ_REFRESH   = 3'd5;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] col;
		logic       row;
		logic [7:0] char_code;
		logic [4:0] span_len;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [3:0] out_col;
		logic       out_row;
		logic [7:0] out_char;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;      // latch the incoming request
		logic init_step;   // reset clearing pass, one cell
		logic put_pos;     // write at given position, move cursor
		logic put_cur;     // write at cursor, advance cursor
		logic set_cur;     // move cursor
		logic span_start;  // set up a span clear
		logic all_start;   // set up a full clear
		logic fill_step;   // write one space, advance
		logic scan_start;  // set up a refresh scan
		logic scan_step;   // issue/compare one cell
		logic emit;        // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] req_type;
		logic       idx_last;
		logic       span_empty;
		logic       fill_last;
		logic       scan_end;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/char_display_diff_refresh.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_display_diff_refresh
// Wanted/shown character grids with a cursor; a refresh tick reports the
// first cell, in row-major order, whose wanted character has not been shown.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | beat carries
//  --------+------------------------------+-----------------------------------
//  req     | req_valid, req_ready, req    | one request (req_t)
//  rsp     | rsp_valid, rsp_ready, rsp    | one refresh result (rsp_t)
//
//  Sweeps: clear span fills the span length clipped at the line end, clear
//  all fills the whole grid, and a refresh stops at the first differing
//  cell; the refresh walks the grid one cell a cycle over the grid memory
//  read port.
//  Reset: a clearing pass over every cell loads spaces into the wanted
//  grid and zeros into the shown grid; req_ready stays low meanwhile.
//  Stalls: a pending rsp beat does not block requests; only the hand-off of
//  the next refresh result waits for the output register to free up.
//
module char_display_diff_refresh import cdr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_ready,
	input  wire  req_t req,
	output logic       rsp_valid,
	input  wire  logic rsp_ready,
	output rsp_t       rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: decode, sweep and scan control
	cdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// grids, cursor, counters and output register
	cdr_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.sts       (sts)
	);

endmodule
`default_nettype wire

### src/cdr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_ctrl
// Sequencer: reset clearing pass, request decode, fill sweeps, refresh scan
// and result hand-off.
// ----------------------------------------------------------------------------
module cdr_ctrl import cdr_pkg::*; (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_ready,
	input  wire  sts_t sts,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (sts.req_type)
					REQ_PUT_POS: cmd.put_pos = 1'b1;
					REQ_PUT_CUR: cmd.put_cur = 1'b1;
					REQ_SET_CUR: cmd.set_cur = 1'b1;
					REQ_CLR_SPAN: begin
						cmd.span_start = 1'b1;
						if (!sts.span_empty) state_d = ST_FILL;
					end
					REQ_CLR_ALL: begin
						cmd.all_start = 1'b1;
						state_d       = ST_FILL;
					end
					REQ_REFRESH: begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

### src/cdr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_dpath
// Grid memories, cursor, sweep counters, scan pipeline and output register.
// ----------------------------------------------------------------------------
module cdr_dpath import cdr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  cmd_t cmd,
	input  wire  req_t req,
	input  wire  logic rsp_ready,
	output logic       rsp_valid,
	output rsp_t       rsp,
	output sts_t       sts
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIW   = $clog2(CELLS);
	localparam int FLW   = $clog2(CELLS + 1);

	logic [7:0] wanted_mem [CELLS];
	logic [7:0] shown_mem  [CELLS];

	// latched request
	logic [2:0]   req_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [7:0]   ch_q;
	logic [4:0]   len_q;

	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;

	logic [CIW-1:0] idx_q;
	logic [FLW-1:0] left_q;
	logic [CW-1:0]  scol_q;
	logic [RW-1:0]  srow_q;
	logic           issued_all_q;

	logic           v_s1;
	logic           last_s1;
	logic [CIW-1:0] idx_s1;
	logic [CW-1:0]  col_s1;
	logic [RW-1:0]  row_s1;
	logic [7:0]     wrd_s1;
	logic [7:0]     srd_s1;

	rsp_t res_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// clamp of incoming position
	logic [31:0]   col_ext, row_ext;
	logic [CW-1:0] c_cl;
	logic [RW-1:0] r_cl;

	assign col_ext = 32'(req.col);
	assign row_ext = 32'(req.row);
	assign c_cl = (col_ext > 32'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(col_ext);
	assign r_cl = (row_ext > 32'(ROWS - 1))    ? RW'(ROWS - 1)    : RW'(row_ext);

	// cell addresses
	logic [CIW-1:0] pos_addr, cur_addr;
	assign pos_addr = CIW'(32'(r_q) * COLUMNS + 32'(c_q));
	assign cur_addr = CIW'(32'(cur_row_q) * COLUMNS + 32'(cur_col_q));

	// span length clipped at the line end
	logic [31:0] room, len32, span_cnt;
	assign room     = 32'(COLUMNS) - 32'(c_q);
	assign len32    = 32'(len_q);
	assign span_cnt = (len32 < room) ? len32 : room;

	// scan compare
	logic hit, end_miss, issue;
	assign hit      = v_s1 && (wrd_s1 != srd_s1);
	assign end_miss = v_s1 && last_s1 && !hit;
	assign issue    = cmd.scan_step && !issued_all_q && !hit;

	// wanted grid write port
	logic           w_we;
	logic [CIW-1:0] w_addr;
	logic [7:0]     w_data;

	always_comb begin
		w_we   = 1'b1;
		w_addr = idx_q;
		w_data = SPACE_CHAR;
		priority if (cmd.put_pos) begin
			w_addr = pos_addr;
			w_data = ch_q;
		end else if (cmd.put_cur) begin
			w_addr = cur_addr;
			w_data = ch_q;
		end else if (cmd.init_step || cmd.fill_step) begin
			w_addr = idx_q;
		end else begin
			w_we = 1'b0;
		end
	end

	// shown grid write port
	logic           s_we;
	logic [CIW-1:0] s_addr;
	logic [7:0]     s_data;

	always_comb begin
		s_we   = cmd.init_step || (cmd.scan_step && hit);
		s_addr = cmd.init_step ? idx_q : idx_s1;
		s_data = cmd.init_step ? 8'h00 : wrd_s1;
	end

	always_ff @(posedge clk) begin
		if (w_we)  wanted_mem[w_addr] <= w_data;
		if (issue) wrd_s1 <= wanted_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (s_we)  shown_mem[s_addr] <= s_data;
		if (issue) srd_s1 <= shown_mem[idx_q];
	end

	// request latch and scan stage payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req.req_type;
			c_q   <= c_cl;
			r_q   <= r_cl;
			ch_q  <= req.char_code;
			len_q <= req.span_len;
		end
		if (issue) begin
			idx_s1  <= idx_q;
			col_s1  <= scol_q;
			row_s1  <= srow_q;
			last_s1 <= (idx_q == CIW'(CELLS - 1));
		end
		if (cmd.scan_step && hit) begin
			res_q.found    <= 1'b1;
			res_q.out_col  <= 4'({{4{1'b0}}, col_s1});
			res_q.out_row  <= row_s1[0];
			res_q.out_char <= wrd_s1;
		end else if (cmd.scan_step && end_miss) begin
			res_q <= '0;
		end
		if (cmd.emit) rsp_q <= res_q;
	end

	// control state: cursor, counters, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			idx_q        <= '0;
			left_q       <= '0;
			scol_q       <= '0;
			srow_q       <= '0;
			issued_all_q <= 1'b0;
			v_s1         <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.put_pos || cmd.set_cur || cmd.span_start) begin
				cur_col_q <= c_q;
				cur_row_q <= r_q;
			end else if (cmd.put_cur) begin
				if (cur_col_q != CW'(COLUMNS - 1)) cur_col_q <= cur_col_q + 1'b1;
			end else if (cmd.all_start) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
			end

			if (cmd.init_step || cmd.fill_step) idx_q <= idx_q + 1'b1;
			if (cmd.fill_step) left_q <= left_q - 1'b1;

			if (cmd.span_start) begin
				idx_q  <= pos_addr;
				left_q <= FLW'(span_cnt);
			end
			if (cmd.all_start) begin
				idx_q  <= '0;
				left_q <= FLW'(CELLS);
			end

			if (cmd.scan_start) begin
				idx_q        <= '0;
				scol_q       <= '0;
				srow_q       <= '0;
				issued_all_q <= 1'b0;
				v_s1         <= 1'b0;
			end else if (cmd.scan_step) begin
				v_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CIW'(CELLS - 1)) issued_all_q <= 1'b1;
					if (scol_q == CW'(COLUMNS - 1)) begin
						scol_q <= '0;
						srow_q <= srow_q + 1'b1;
					end else begin
						scol_q <= scol_q + 1'b1;
					end
				end
			end

			if (cmd.emit)                rsp_valid_q <= 1'b1;
			else if (rsp_ready)          rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.req_type   = req_q;
	assign sts.idx_last   = (idx_q == CIW'(CELLS - 1));
	assign sts.span_empty = (span_cnt == 32'd0);
	assign sts.fill_last  = (left_q == FLW'(1));
	assign sts.scan_end   = hit || end_miss;
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

endmodule
`default_nettype wire
